### hw/rtl/rae_pkg.sv
// shared types and constants of the register alu execute block
// opcodes, status codes, back-end states and the inter-module structs
// no dependencies
`timescale 1ns / 1ps

package rae_pkg;

   localparam int FIELD_WIDTH = 4;
   localparam int FIELD_COUNT = 16;
   localparam int IMM_WIDTH   = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      OP_LOADI = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_MUL   = 4'd3,
      OP_DIV   = 4'd4,
      OP_MOV   = 4'd5,
      OP_NOT   = 4'd6,
      OP_EQ    = 4'd7,
      OP_LT    = 4'd8,
      OP_LE    = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNKNOWN  = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_ITER
   } back_state_type;

   // classification produced by the front end
   typedef struct packed {
      op_type                 op;
      logic                   unknown;
      logic [FIELD_WIDTH-1:0] dfield;
   } class_type;

   // control from the back end to the iterative unit
   typedef struct packed {
      logic start;
      logic divide;
   } iter_ctl_type;

endpackage

### hw/rtl/register_alu_execute_core.sv
// top level of the register alu execute block
// depends on rae_pkg, rae_front, rae_queue and rae_back
`timescale 1ns / 1ps

// register alu execute core: runs one three-operand instruction per request
// against a file of REGISTER_COUNT registers of VALUE_WIDTH bits
//
// request channel: a transfer happens at a rising edge with start high and
//   busy low; busy is high only while the two-entry queue is full
// response channel: one response per request, in order; rsp_strobe is high
//   for exactly one cycle and the response is taken at the edge ending it;
//   the receiver cannot stall, so nothing waits on the output side
//
// timing: a simple instruction goes through the back-end states dequeue, then
//   operand read, execute and write back, and the response is registered;
//   mul and nonzero div use the bit-serial unit, one bit per cycle, and
//   the serial unit sets the worst rate
//
// reset: all registers read as zero after reset (per-register valid bits),
//   queue empty, no response pending
module register_alu_execute_core #(
   parameter int REGISTER_COUNT = 16,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]      req_command,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]      req_first_source,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]      req_second_source,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]      req_destination,
   input  logic signed [rae_pkg::IMM_WIDTH-1:0] req_immediate,
   output logic                                 rsp_strobe,
   output logic signed [rae_pkg::OUT_WIDTH-1:0] rsp_written_value,
   output logic [rae_pkg::FIELD_WIDTH-1:0]      rsp_written_index,
   output logic [1:0]                           rsp_status
);
   import rae_pkg::*;

   localparam int IW          = $clog2(REGISTER_COUNT);
   localparam int CLS_WIDTH   = $bits(class_type);
   localparam int ENTRY_WIDTH = CLS_WIDTH + 3 * IW + VALUE_WIDTH;

   // front end outputs
   class_type              f_cls;
   logic [IW-1:0]          f_s1, f_s2, f_d;
   logic [VALUE_WIDTH-1:0] f_imm;

   // queue
   logic                   push, pop, q_empty, q_full;
   logic [ENTRY_WIDTH-1:0] push_data, pop_data;

   // queue head, unpacked for the back end
   class_type              h_cls;
   logic [IW-1:0]          h_s1, h_s2, h_d;
   logic [VALUE_WIDTH-1:0] h_imm;

   logic [OUT_WIDTH-1:0]   b_value;
   status_type             b_status;

   rae_front #(.REGISTER_COUNT(REGISTER_COUNT), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .command       (req_command),
      .first_source  (req_first_source),
      .second_source (req_second_source),
      .destination   (req_destination),
      .immediate     (req_immediate),
      .cls           (f_cls),
      .s1_idx        (f_s1),
      .s2_idx        (f_s2),
      .d_idx         (f_d),
      .imm_val       (f_imm)
   );

   // request transfer goes straight into the queue
   assign busy      = q_full;
   assign push      = start && !q_full;
   assign push_data = {f_cls, f_s1, f_s2, f_d, f_imm};

   rae_queue #(.WIDTH(ENTRY_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign {h_cls, h_s1, h_s2, h_d, h_imm} = pop_data;

   rae_back #(.REGISTER_COUNT(REGISTER_COUNT), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head_cls   (h_cls),
      .head_s1    (h_s1),
      .head_s2    (h_s2),
      .head_d     (h_d),
      .head_imm   (h_imm),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (b_value),
      .rsp_index  (rsp_written_index),
      .rsp_status (b_status)
   );

   assign rsp_written_value = $signed(b_value);
   assign rsp_status        = b_status;

endmodule

### hw/rtl/rae_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rae_iter.sv
// shared bit-serial unit: shift-add multiply and restoring signed divide
// one bit per cycle; depends on rae_pkg
`timescale 1ns / 1ps

module rae_iter #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rae_pkg::iter_ctl_type     ctl,
   input  logic [VALUE_WIDTH-1:0]    operand_a,
   input  logic [VALUE_WIDTH-1:0]    operand_b,
   output logic                      done,
   output logic [VALUE_WIDTH-1:0]    result
);
   import rae_pkg::*;

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   divide_ff, divide_in;
   logic                   negate_ff, negate_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH:0]   rem_shift;
   logic [VALUE_WIDTH:0]   rem_diff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      divide_in = divide_ff;
      negate_in = negate_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      rem_shift = {acc_ff, x_ff[VALUE_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, y_ff};
      if (ctl.start) begin
         busy_in   = 1'b1;
         divide_in = ctl.divide;
         count_in  = CW'(VALUE_WIDTH);
         acc_in    = '0;
         if (ctl.divide) begin
            // divide on magnitudes, fix the sign at the end
            negate_in = operand_a[VALUE_WIDTH-1] ^ operand_b[VALUE_WIDTH-1];
            x_in = operand_a[VALUE_WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
            y_in = operand_b[VALUE_WIDTH-1] ? (~operand_b + 1'b1) : operand_b;
         end else begin
            negate_in = 1'b0;
            x_in      = operand_a;
            y_in      = operand_b;
         end
      end else if (busy_ff) begin
         if (divide_ff) begin
            if (!rem_diff[VALUE_WIDTH]) begin
               acc_in = rem_diff[VALUE_WIDTH-1:0];
               x_in   = {x_ff[VALUE_WIDTH-2:0], 1'b1};
            end else begin
               acc_in = rem_shift[VALUE_WIDTH-1:0];
               x_in   = {x_ff[VALUE_WIDTH-2:0], 1'b0};
            end
         end else begin
            if (x_ff[0]) begin
               acc_in = acc_ff + y_ff;
            end
            x_in = x_ff >> 1;
            y_in = y_ff << 1;
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      divide_ff <= divide_in;
      negate_ff <= negate_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      count_ff  <= count_in;
   end

   assign done   = done_ff;
   assign result = divide_ff ? (negate_ff ? (~x_ff + 1'b1) : x_ff) : acc_ff;

endmodule

### hw/rtl/rae_front.sv
// front end: classifies a request, reduces register indexes, widens the immediate
// depends on rae_pkg
`timescale 1ns / 1ps

module rae_front #(
   parameter int REGISTER_COUNT = 16,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic [rae_pkg::FIELD_WIDTH-1:0]    command,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]    first_source,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]    second_source,
   input  logic [rae_pkg::FIELD_WIDTH-1:0]    destination,
   input  logic signed [rae_pkg::IMM_WIDTH-1:0] immediate,
   output rae_pkg::class_type                 cls,
   output logic [$clog2(REGISTER_COUNT)-1:0]  s1_idx,
   output logic [$clog2(REGISTER_COUNT)-1:0]  s2_idx,
   output logic [$clog2(REGISTER_COUNT)-1:0]  d_idx,
   output logic [VALUE_WIDTH-1:0]             imm_val
);
   import rae_pkg::*;

   localparam int IW = $clog2(REGISTER_COUNT);

   // index reduction as a constant lookup over the 16 field codes
   always_comb begin
      s1_idx = '0;
      s2_idx = '0;
      d_idx  = '0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
         if (first_source == FIELD_WIDTH'(k)) begin
            s1_idx = IW'(k % REGISTER_COUNT);
         end
         if (second_source == FIELD_WIDTH'(k)) begin
            s2_idx = IW'(k % REGISTER_COUNT);
         end
         if (destination == FIELD_WIDTH'(k)) begin
            d_idx = IW'(k % REGISTER_COUNT);
         end
      end
   end

   always_comb begin
      cls.unknown = (command > OP_LE);
      cls.op      = cls.unknown ? OP_LOADI : op_type'(command);
      cls.dfield  = destination;
   end

   assign imm_val = VALUE_WIDTH'(immediate);

endmodule

### hw/rtl/rae_queue.sv
// small fifo between front and back end
// depends on rae_pkg
`timescale 1ns / 1ps

module rae_queue #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   import rae_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign pop_data = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/rae_back.sv
// back end: register file banks, execution sequencer and result register
// depends on rae_pkg, rae_ram and rae_iter
`timescale 1ns / 1ps

module rae_back #(
   parameter int REGISTER_COUNT = 16,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              empty,
   input  rae_pkg::class_type                head_cls,
   input  logic [$clog2(REGISTER_COUNT)-1:0] head_s1,
   input  logic [$clog2(REGISTER_COUNT)-1:0] head_s2,
   input  logic [$clog2(REGISTER_COUNT)-1:0] head_d,
   input  logic [VALUE_WIDTH-1:0]            head_imm,
   output logic                              pop,
   output logic                              rsp_strobe,
   output logic [rae_pkg::OUT_WIDTH-1:0]     rsp_value,
   output logic [rae_pkg::FIELD_WIDTH-1:0]   rsp_index,
   output rae_pkg::status_type               rsp_status
);
   import rae_pkg::*;

   localparam int IW = $clog2(REGISTER_COUNT);

   back_state_type         state_ff, state_in;
   op_type                 op_ff;
   logic                   unknown_ff;
   logic [FIELD_WIDTH-1:0] dfield_ff;
   logic [IW-1:0]          d_ff;
   logic [VALUE_WIDTH-1:0] imm_ff;
   logic                   va_ff, vb_ff;
   logic [REGISTER_COUNT-1:0] valid_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic [FIELD_WIDTH-1:0] rsp_index_ff, rsp_index_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic [VALUE_WIDTH-1:0] rd_a, rd_b, a, b;
   logic [VALUE_WIDTH-1:0] result;
   logic                   finish;
   status_type             status;
   logic                   wr_en;
   iter_ctl_type           iter_ctl;
   logic                   iter_done;
   logic [VALUE_WIDTH-1:0] iter_result;

   // two banks written together give two read ports
   rae_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(REGISTER_COUNT)) u_bank_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (d_ff),
      .wr_data (result),
      .rd_addr (head_s1),
      .rd_data (rd_a)
   );

   rae_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(REGISTER_COUNT)) u_bank_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (d_ff),
      .wr_data (result),
      .rd_addr (head_s2),
      .rd_data (rd_b)
   );

   rae_iter #(.VALUE_WIDTH(VALUE_WIDTH)) u_iter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (iter_ctl),
      .operand_a (a),
      .operand_b (b),
      .done      (iter_done),
      .result    (iter_result)
   );

   // never-written registers read as zero
   assign a = va_ff ? rd_a : '0;
   assign b = vb_ff ? rd_b : '0;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      iter_ctl = '0;
      result   = '0;
      finish   = 1'b0;
      status   = ST_OK;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            finish = 1'b1;
            if (unknown_ff) begin
               status = ST_UNKNOWN;
            end else begin
               case (op_ff)
                  OP_LOADI: result = imm_ff;
                  OP_ADD:   result = a + b;
                  OP_SUB:   result = a - b;
                  OP_MUL: begin
                     iter_ctl.start = 1'b1;
                     finish         = 1'b0;
                  end
                  OP_DIV: begin
                     if (b == '0) begin
                        status = ST_DIV_ZERO;
                     end else begin
                        iter_ctl.start  = 1'b1;
                        iter_ctl.divide = 1'b1;
                        finish          = 1'b0;
                     end
                  end
                  OP_MOV:   result = a;
                  OP_NOT:   result = VALUE_WIDTH'(a == '0);
                  OP_EQ:    result = VALUE_WIDTH'(a == b);
                  OP_LT:    result = VALUE_WIDTH'($signed(a) < $signed(b));
                  OP_LE:    result = VALUE_WIDTH'($signed(a) <= $signed(b));
                  default:  status = ST_UNKNOWN;
               endcase
            end
            state_in = finish ? BK_IDLE : BK_ITER;
         end
         BK_ITER: begin
            if (iter_done) begin
               result   = iter_result;
               finish   = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      wr_en         = finish && (status == ST_OK);
      rsp_strobe_in = finish;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      if (finish) begin
         rsp_value_in  = (status == ST_OK) ? OUT_WIDTH'(result) : '0;
         rsp_index_in  = dfield_ff;
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (wr_en) begin
            valid_ff[d_ff] <= 1'b1;
         end
      end
      if (pop) begin
         op_ff      <= head_cls.op;
         unknown_ff <= head_cls.unknown;
         dfield_ff  <= head_cls.dfield;
         d_ff       <= head_d;
         imm_ff     <= head_imm;
         va_ff      <= valid_ff[head_s1];
         vb_ff      <= valid_ff[head_s2];
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_status = rsp_status_ff;

   ap_start_from_read: assert property (@(posedge clock) disable iff (reset)
      iter_ctl.start |-> state_ff == BK_READ)
      else $error("iterative unit started outside operand read");

   ap_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0)
      else $error("failed instruction reported a nonzero value");

   ap_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(d_ff)])
      else $error("written register not marked valid");

   ap_iter_done_reports: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ITER && iter_done |=> rsp_strobe_ff)
      else $error("finished mul/div produced no response");

   ap_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back-to-back responses from a sequential back end");

endmodule
